>>> design/bdi_pkg.sv
// bdi_pkg: shared types, plan table and segment evaluation functions
// for the base-delta-immediate line compression selector; no dependencies
`timescale 1ns / 1ps

package bdi_pkg;

    localparam int unsigned NUM_PLANS = 12;

    localparam logic [3:0] ENC_ZERO         = 4'd0;
    localparam logic [3:0] ENC_REPEAT       = 4'd1;
    localparam logic [3:0] ENC_UNCOMPRESSED = 4'd14;

    localparam logic [7:0] CFG_ALLOW_IMMEDIATE = 8'd0;
    localparam logic [7:0] CFG_LITTLE_ENDIAN   = 8'd1;

    // plans in priority order
    localparam logic [3:0] PLAN_ENC [NUM_PLANS] =
        '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13};
    localparam int unsigned PLAN_SEG [NUM_PLANS] =
        '{8, 8, 4, 8, 4, 8, 8, 4, 2, 2, 4, 8};
    localparam int unsigned PLAN_DELTA [NUM_PLANS] =
        '{1, 2, 1, 1, 1, 2, 4, 2, 1, 1, 2, 4};
    localparam logic PLAN_BDI [NUM_PLANS] =
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    typedef struct packed {
        logic        fail;
        logic        have_base;
        logic [63:0] base;
        logic [31:0] mask;
    } plan_st_t;

    typedef plan_st_t [NUM_PLANS-1:0] plan_vec_t;

    typedef struct packed {
        logic        all_zero;
        logic        all_same;
        logic [63:0] first_word;
        plan_vec_t   plans;
    } line_sum_t;

    function automatic logic [63:0] seg_mask(int unsigned s);
        return (s == 8) ? 64'hffff_ffff_ffff_ffff : ((64'd1 << (8 * s)) - 64'd1);
    endfunction

    // signed value of s bytes fits in d signed bytes
    function automatic logic fits(logic [63:0] x, int unsigned s, int unsigned d);
        logic [63:0] t;
        t = (x + (64'd1 << (8 * d - 1))) & seg_mask(s);
        return (t >> (8 * d)) == 64'd0;
    endfunction

    // fold the segments of one word into the running state of one plan
    function automatic plan_st_t eval_word(plan_st_t st, logic [63:0] w, logic [3:0] widx,
                                           int unsigned s, int unsigned d, logic is_bdi,
                                           logic le);
        plan_st_t    r;
        logic [63:0] v;
        logic [63:0] b;
        logic [5:0]  k;
        int unsigned n;
        r = st;
        n = (s == 2) ? 4 : ((s == 4) ? 2 : 1);
        for (int unsigned j = 0; j < 4; j++) begin
            if (j < n) begin
                v = 64'd0;
                for (int unsigned i = 0; i < 8; i++) begin
                    if (i < s) begin
                        b = {56'd0, w[8*(j*s+i) +: 8]};
                        v = le ? (v | (b << (8 * i))) : ((v << 8) | b);
                    end
                end
                k = 6'(widx * n + j);
                if (fits(v, s, d)) begin
                    if (k < 6'd32) r.mask[k[4:0]] = 1'b1;
                end else if (!is_bdi) begin
                    r.fail = 1'b1;
                end else begin
                    if (!r.have_base) begin
                        r.have_base = 1'b1;
                        r.base      = v;
                    end
                    if (!fits((v - r.base) & seg_mask(s), s, d)) r.fail = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

>>> design/bdi_front.sv
// bdi_front: accepts line words and folds each into the per-plan state
// depends on bdi_pkg
`timescale 1ns / 1ps

module bdi_front #(
    parameter int LINE_WORDS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_line_word,
    input  logic               little_endian,
    input  logic               q_full,
    output logic               q_push,
    output bdi_pkg::line_sum_t q_data
);
    import bdi_pkg::*;

    localparam int CW = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;

    logic [CW-1:0] count_reg, count_next;
    plan_vec_t     plans_reg, plans_next, plans_cur;
    logic          zero_reg, zero_next, same_reg, same_next;
    logic [63:0]   first_reg, first_next;
    logic          accept, last, start;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign last    = (32'(count_reg) == LINE_WORDS - 1);
    assign start   = (count_reg == '0);

    always_comb begin
        plans_cur  = start ? '0 : plans_reg;
        first_next = start ? s_line_word : first_reg;
        zero_next  = (start || zero_reg) && (s_line_word == 64'd0);
        same_next  = (start || same_reg) && (s_line_word == first_next);
        for (int p = 0; p < NUM_PLANS; p++) begin
            plans_next[p] = eval_word(plans_cur[p], s_line_word, 4'(count_reg),
                                      PLAN_SEG[p], PLAN_DELTA[p], PLAN_BDI[p],
                                      little_endian);
        end
        count_next = last ? '0 : count_reg + CW'(1);
    end

    assign q_push = accept && last;
    assign q_data = '{all_zero: zero_next, all_same: same_next,
                      first_word: first_next, plans: plans_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            plans_reg <= plans_next;
            zero_reg  <= zero_next;
            same_reg  <= same_next;
            first_reg <= first_next;
        end
    end

endmodule

>>> design/bdi_queue.sv
// bdi_queue: two-entry queue of line summaries between front and back
// depends on bdi_pkg
`timescale 1ns / 1ps

module bdi_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  bdi_pkg::line_sum_t push_data,
    output logic               full,
    output logic               not_empty,
    input  logic               pop,
    output bdi_pkg::line_sum_t pop_data
);
    import bdi_pkg::*;

    line_sum_t  mem_reg [2];
    logic       wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");

endmodule

>>> design/bdi_back.sv
// bdi_back: picks the first successful encoding and holds the result register
// depends on bdi_pkg
`timescale 1ns / 1ps

module bdi_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               allow_immediate,
    input  logic               q_valid,
    output logic               q_pop,
    input  bdi_pkg::line_sum_t q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_encoding,
    output logic [3:0]         m_base_bytes,
    output logic [2:0]         m_delta_bytes,
    output logic [63:0]        m_base_value,
    output logic [31:0]        m_immediate_mask
);
    import bdi_pkg::*;

    logic        valid_reg, valid_next;
    logic [3:0]  enc_reg, enc_next, bb_reg, bb_next;
    logic [2:0]  db_reg, db_next;
    logic [63:0] base_reg, base_next;
    logic [31:0] mask_reg, mask_next;
    logic        found;

    assign q_pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        enc_next  = ENC_UNCOMPRESSED;
        bb_next   = 4'd0;
        db_next   = 3'd0;
        base_next = 64'd0;
        mask_next = 32'd0;
        found     = 1'b0;
        priority if (q_data.all_zero) begin
            enc_next = ENC_ZERO;
        end else if (q_data.all_same) begin
            enc_next  = ENC_REPEAT;
            bb_next   = 4'd8;
            base_next = q_data.first_word;
        end else begin
            for (int p = 0; p < NUM_PLANS; p++) begin
                if (!found && !q_data.plans[p].fail && (PLAN_BDI[p] || allow_immediate)) begin
                    found     = 1'b1;
                    enc_next  = PLAN_ENC[p];
                    bb_next   = 4'(PLAN_SEG[p]);
                    db_next   = 3'(PLAN_DELTA[p]);
                    base_next = q_data.plans[p].base;
                    mask_next = q_data.plans[p].mask;
                end
            end
        end
        valid_next = q_valid || (valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            enc_reg  <= enc_next;
            bb_reg   <= bb_next;
            db_reg   <= db_next;
            base_reg <= base_next;
            mask_reg <= mask_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_encoding       = enc_reg;
    assign m_base_bytes     = bb_reg;
    assign m_delta_bytes    = db_reg;
    assign m_base_value     = base_reg;
    assign m_immediate_mask = mask_reg;

endmodule

>>> design/bdi_line_compress_select.sv
// bdi_line_compress_select: top level of the line compression selector
// depends on bdi_pkg, bdi_front, bdi_queue, bdi_back
`timescale 1ns / 1ps

// a cache line arrives as LINE_WORDS 64-bit items, one per cycle while the
// queue is not full, lowest address first; the segments of each item are
// folded at once into a running state for every candidate encoding, so no
// line buffer is replayed. after the last item of a line the summary goes
// into a two-entry queue and the back end picks the first encoding that
// succeeds (zero, repeat, then the immediate and base-delta forms) from it
// into the output register. sustained rate is one item per cycle while the
// queue is not full; the summary is registered in the queue and the result
// item in the output register.
// the input stalls only when both queue entries are occupied by lines whose
// results wait.
// configuration writes are always taken (cfg_ready is tied high).

module bdi_line_compress_select #(
    parameter int LINE_WORDS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic        cfg_data,
    // line word items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_line_word,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_encoding,
    output logic [3:0]  m_base_bytes,
    output logic [2:0]  m_delta_bytes,
    output logic [63:0] m_base_value,
    output logic [31:0] m_immediate_mask
);
    import bdi_pkg::*;

    logic      allow_imm_reg, allow_imm_next;
    logic      le_reg, le_next;
    logic      q_full, q_push, q_valid, q_pop;
    line_sum_t q_in, q_out;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        allow_imm_next = allow_imm_reg;
        le_next        = le_reg;
        if (cfg_valid) begin
            if (cfg_index == CFG_ALLOW_IMMEDIATE) allow_imm_next = cfg_data;
            if (cfg_index == CFG_LITTLE_ENDIAN) le_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_imm_reg <= 1'b1;
            le_reg        <= 1'b1;
        end else begin
            allow_imm_reg <= allow_imm_next;
            le_reg        <= le_next;
        end
    end

    // front: take items, fold segments
    bdi_front #(.LINE_WORDS(LINE_WORDS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_line_word   (s_line_word),
        .little_endian (le_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    // queue between the two halves
    bdi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .not_empty (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    // back: priority select and result register
    bdi_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .allow_immediate  (allow_imm_reg),
        .q_valid          (q_valid),
        .q_pop            (q_pop),
        .q_data           (q_out),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_encoding       (m_encoding),
        .m_base_bytes     (m_base_bytes),
        .m_delta_bytes    (m_delta_bytes),
        .m_base_value     (m_base_value),
        .m_immediate_mask (m_immediate_mask)
    );

    // zero and uncompressed results carry no sizes and no mask
    a_zero_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_encoding == ENC_ZERO || m_encoding == ENC_UNCOMPRESSED)
        |-> m_base_bytes == 4'd0 && m_immediate_mask == 32'd0)
        else $error("zero or uncompressed result has payload");
    // repeat result always uses 8-byte segments and no deltas
    a_repeat_sizes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_encoding == ENC_REPEAT |-> m_base_bytes == 4'd8 && m_delta_bytes == 3'd0)
        else $error("repeat result sizes wrong");
    // input stalls only while the queue holds two lines
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_full && q_valid)
        else $error("input stalled without full queue");

endmodule

>>> sim/bdi_line_checker.sv
// bdi_line_checker: watches the line word and result channels, predicts the
// encoding choice of each completed line and compares; depends on bdi_pkg
`timescale 1ns / 1ps

module bdi_line_checker #(
    parameter int LINE_WORDS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_line_word,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_encoding,
    input  logic [3:0]  m_base_bytes,
    input  logic [2:0]  m_delta_bytes,
    input  logic [63:0] m_base_value,
    input  logic [31:0] m_immediate_mask,
    output int          fail_count,
    output int          pending_lines
);
    import bdi_pkg::*;

    typedef struct packed {
        logic [3:0]  encoding;
        logic [3:0]  base_bytes;
        logic [2:0]  delta_bytes;
        logic [63:0] base_value;
        logic [31:0] immediate_mask;
    } line_choice_t;

    line_choice_t expected_choices[$];
    logic [63:0]  words[LINE_WORDS];
    int           word_idx;
    logic         imm_en;
    logic         le_mode;

    function automatic logic [63:0] seg_of(int k, int s, logic le);
        logic [63:0] v;
        logic [63:0] bt;
        int          b;
        v = 0;
        for (int j = 0; j < s; j++) begin
            b = k * s + j;
            bt = (words[b / 8] >> (8 * (b % 8))) & 64'hff;
            if (le) v = v | (bt << (8 * j));
            else v = (v << 8) | bt;
        end
        return v;
    endfunction

    function automatic logic fits_in(logic [63:0] x, int s, int d);
        logic [63:0] t;
        logic [63:0] m;
        m = (s == 8) ? '1 : ((64'd1 << (8 * s)) - 1);
        t = (x + (64'd1 << (8 * d - 1))) & m;
        return (t >> (8 * d)) == 0;
    endfunction

    // try one segment/delta form; returns success with base and mask
    function automatic logic try_form(int s, int d, logic bdi, logic le,
                                      output logic [63:0] base, output logic [31:0] mask);
        int          n;
        logic        have;
        logic [63:0] v;
        logic [63:0] m;
        n = LINE_WORDS * 8 / s;
        m = (s == 8) ? '1 : ((64'd1 << (8 * s)) - 1);
        base = 0;
        mask = 0;
        have = 0;
        for (int k = 0; k < n; k++) begin
            v = seg_of(k, s, le);
            if (fits_in(v, s, d)) begin
                if (k < 32) mask[k] = 1'b1;
            end else if (!bdi) begin
                return 1'b0;
            end else begin
                if (!have) begin
                    have = 1;
                    base = v;
                end
                if (!fits_in((v - base) & m, s, d)) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic line_choice_t choose_encoding(logic imm, logic le);
        line_choice_t c;
        logic         zero_line;
        logic         same_line;
        logic [63:0]  b;
        logic [31:0]  mk;
        c = '0;
        c.encoding = ENC_UNCOMPRESSED;
        zero_line = 1;
        same_line = 1;
        for (int i = 0; i < LINE_WORDS; i++) begin
            if (words[i] != 0) zero_line = 0;
            if (words[i] != words[0]) same_line = 0;
        end
        if (zero_line) begin
            c.encoding = ENC_ZERO;
        end else if (same_line) begin
            c.encoding = ENC_REPEAT;
            c.base_bytes = 8;
            c.base_value = words[0];
        end else begin
            for (int p = 0; p < NUM_PLANS; p++) begin
                if (!PLAN_BDI[p] && !imm) continue;
                if (try_form(PLAN_SEG[p], PLAN_DELTA[p], PLAN_BDI[p], le, b, mk)) begin
                    c.encoding = PLAN_ENC[p];
                    c.base_bytes = 4'(PLAN_SEG[p]);
                    c.delta_bytes = 3'(PLAN_DELTA[p]);
                    c.base_value = b;
                    c.immediate_mask = mk;
                    break;
                end
            end
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    assign pending_lines = expected_choices.size();

    always @(posedge aclk) begin
        line_choice_t want;
        if (!aresetn) begin
            word_idx <= 0;
            imm_en <= 1'b1;
            le_mode <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ALLOW_IMMEDIATE) imm_en <= cfg_data;
                else if (cfg_index == CFG_LITTLE_ENDIAN) le_mode <= cfg_data;
            end
            if (s_valid && s_ready) begin
                words[word_idx] = s_line_word;
                if (word_idx == LINE_WORDS - 1) begin
                    expected_choices.insert(expected_choices.size(),
                                            choose_encoding(imm_en, le_mode));
                    word_idx <= 0;
                end else begin
                    word_idx <= word_idx + 1;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_choices.size() == 0) begin
                    report_mismatch("unexpected result item", {60'd0, m_encoding}, 64'd0);
                end else begin
                    want = expected_choices.pop_front();
                    if (m_encoding != want.encoding)
                        report_mismatch("encoding", m_encoding, want.encoding);
                    if (m_base_bytes != want.base_bytes)
                        report_mismatch("base_bytes", m_base_bytes, want.base_bytes);
                    if (m_delta_bytes != want.delta_bytes)
                        report_mismatch("delta_bytes", m_delta_bytes, want.delta_bytes);
                    if (m_base_value != want.base_value)
                        report_mismatch("base_value", m_base_value, want.base_value);
                    if (m_immediate_mask != want.immediate_mask)
                        report_mismatch("immediate_mask", m_immediate_mask,
                                        want.immediate_mask);
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

>>> sim/tb_bdi_line_compress_select.sv
// tb_bdi_line_compress_select: stimulus and verdict for the line compression
// selector; depends on bdi_pkg, the design sources and bdi_line_checker
`timescale 1ns / 1ps

module tb_bdi_line_compress_select;
    import bdi_pkg::*;

    localparam int LINE_WORDS = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic        cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_line_word;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_encoding;
    logic [3:0]  m_base_bytes;
    logic [2:0]  m_delta_bytes;
    logic [63:0] m_base_value;
    logic [31:0] m_immediate_mask;
    int          fail_count;
    int          pending_lines;
    int          cycle_count;
    logic        hold_off;     // sink held in a long stall

    bdi_line_compress_select #(.LINE_WORDS(LINE_WORDS)) uut (.*);

    bdi_line_checker #(.LINE_WORDS(LINE_WORDS)) checker_i (.*);

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // run limit: counts cycles, gives up on a hang
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result sink: random stalls before each item, or a long hold when asked
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                m_ready <= 1'b1;
                // stay ready until a result item goes through
                @(posedge aclk);
                while (!(m_valid && m_ready)) @(posedge aclk);
            end
        end
    end

    // send one line word item, with a random gap first unless gapless
    task automatic send_word(logic [63:0] w, logic gapless);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_line_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // wait until all lines have returned, then let the back end drain
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_lines != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random segment value of s bytes fitting roughly d bytes signed
    function automatic logic [63:0] small_seg(int s, int d);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v = v >> (64 - 8 * d);
        if (v[8*d-1]) v = v | ~((64'd1 << (8 * d)) - 1);
        if (s < 8) v = v & ((64'd1 << (8 * s)) - 1);
        return v;
    endfunction

    // build one line aimed at a chosen form with random content
    task automatic send_shaped_line(logic gapless);
        logic [63:0] w[LINE_WORDS];
        logic [63:0] base;
        logic [63:0] v;
        int          kind;
        int          s;
        int          d;
        int          n;
        kind = $urandom_range(0, 9);
        s = 2 << $urandom_range(0, 2);
        d = (s == 2) ? 1 : $urandom_range(1, (s == 8) ? 4 : 2);
        n = LINE_WORDS * 8 / s;
        base = {$urandom, $urandom};
        for (int i = 0; i < LINE_WORDS; i++) w[i] = 0;
        for (int k = 0; k < n; k++) begin
            case (kind)
                0: v = 0;
                1: v = base;
                2, 3: v = small_seg(s, d);
                4, 5, 6: v = ($urandom_range(0, 2) == 0) ? small_seg(s, d)
                                                         : base + small_seg(8, d);
                7: v = base + small_seg(8, d) + (($urandom_range(0, 7) == 0) ? 64'h1000 : 0);
                default: v = {$urandom, $urandom};
            endcase
            if (s < 8) v = v & ((64'd1 << (8 * s)) - 1);
            // big-endian byte order is fine: randomly mirror the segment
            if ($urandom_range(0, 1)) begin
                for (int j = 0; j < s; j++)
                    w[(k*s+j)/8][8*((k*s+j)%8) +: 8] = v[8*(s-1-j) +: 8];
            end else begin
                for (int j = 0; j < s; j++)
                    w[(k*s+j)/8][8*((k*s+j)%8) +: 8] = v[8*j +: 8];
            end
        end
        if (kind == 1) for (int i = 0; i < LINE_WORDS; i++) w[i] = base;
        if (kind == 0 && $urandom_range(0, 1)) w[$urandom_range(0, 7)][$urandom_range(0, 63)] = 1;
        for (int i = 0; i < LINE_WORDS; i++) send_word(w[i], gapless);
    endtask

    initial begin
        logic [63:0] dl[16];
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = 1'b0;
        s_valid = 1'b0;
        s_line_word = '0;
        hold_off = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero line, all-ones repeat, small immediates, extremes
        dl = '{64'd0, 64'd0, 64'hffff_ffff_ffff_ffff, 64'h0,
               64'h7f, 64'hffff_ffff_ffff_ff80, 64'h8000_0000_0000_0000, 64'h1,
               64'h0001_0002_0003_0004, 64'h1234_5678_9abc_def0, 64'h5555_aaaa_5555_aaaa,
               64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
               64'h0, 64'h0};
        for (int i = 0; i < 8; i++) send_word(64'd0, 1'b0);          // zero line
        for (int i = 0; i < 8; i++) send_word('1, 1'b0);             // repeat
        for (int i = 4; i < 12; i++) send_word(dl[i], 1'b0);         // mixed extremes
        // partial line held across the write? no: finish the line first
        drain_results();

        // walk all register settings, extremes included
        for (int cfgset = 0; cfgset < 4; cfgset++) begin
            write_reg(CFG_ALLOW_IMMEDIATE, cfgset[0]);
            write_reg(CFG_LITTLE_ENDIAN, cfgset[1]);
            for (int l = 0; l < 48; l++) send_shaped_line($urandom_range(0, 4) == 0);

            // long sink hold while lines keep coming, so the input stalls
            if (cfgset == 1) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(negedge aclk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int l = 0; l < 4; l++) send_shaped_line(1'b1);
                        s_valid <= 1'b0;
                    end
                join
            end
            drain_results();   // sender pause until every result is back
        end

        write_reg(CFG_ALLOW_IMMEDIATE, 1'b1);
        write_reg(CFG_LITTLE_ENDIAN, 1'b1);
        drain_results();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending_lines == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
